// ===== rtl/core/slms_pkg.sv =====
// shared types and constants for the serial link master with status tracking
package slms_pkg;

	// bit phase codes: 1..16 alternate low and high halves of bits 0..7
	localparam logic [4:0] PH_IDLE      = 5'd0;
	localparam logic [4:0] PH_FIRST     = 5'd1;
	localparam logic [4:0] PH_LAST_HIGH = 5'd16;
	localparam logic [4:0] PH_TAIL      = 5'd17;

	// item kinds on the input tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// reply byte codes
	localparam logic [7:0] SYNC_BYTE    = 8'h81;
	localparam logic [7:0] IDLE_LOW     = 8'h00;
	localparam logic [7:0] DISCONNECTED = 8'hFF;

	// configuration register defaults and map
	localparam logic [11:0] HALF_PERIOD_RESET = 12'd62;
	localparam logic        REG_HALF_PERIOD   = 1'b0;

	// reply event from the bit engine to the status tracker
	typedef struct packed {
		logic       done;
		logic [7:0] reply;
		logic       last;
	} slms_reply_t;

	// line and flag levels after one word
	typedef struct packed {
		logic clock_level;
		logic data_level;
		logic busy;
		logic refused;
	} slms_line_t;

endpackage

// ===== rtl/core/slms_link.sv =====
// bit engine: shift registers, half period timer and bit phase sequencing
module slms_link (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                op,
	input  logic [7:0]          tx_byte,
	input  logic                end_of_packet,
	input  logic                serial_in,
	input  logic [11:0]         half_period,
	output slms_pkg::slms_reply_t reply,
	output slms_pkg::slms_line_t  line
);

	logic [7:0]  tx_shift_q, tx_shift_n;
	logic [7:0]  rx_shift_q, rx_shift_n;
	logic [4:0]  phase_q, phase_n;
	logic [11:0] tick_q, tick_n;
	logic [11:0] tick_inc;
	logic [11:0] hp;
	logic        last_q, last_n;
	logic        clock_q, clock_n;
	logic        data_q, data_n;
	logic        busy;

	// next state of the engine for the word in hand
	always_comb begin
		busy       = (phase_q >= slms_pkg::PH_FIRST) && (phase_q <= slms_pkg::PH_TAIL);
		hp         = (half_period == 12'd0) ? 12'd1 : half_period;
		tick_inc   = tick_q + 12'd1;
		tx_shift_n = tx_shift_q;
		rx_shift_n = rx_shift_q;
		phase_n    = busy ? phase_q : slms_pkg::PH_IDLE;
		tick_n     = tick_q;
		last_n     = last_q;
		clock_n    = clock_q;
		data_n     = data_q;
		reply      = '0;
		line.refused = 1'b0;
		if (op == slms_pkg::OP_LOAD) begin
			if (busy) begin
				line.refused = 1'b1;
			end else begin
				tx_shift_n = tx_byte;
				rx_shift_n = 8'd0;
				last_n     = end_of_packet;
				data_n     = tx_byte[7];
				clock_n    = 1'b0;
				tick_n     = 12'd0;
				phase_n    = slms_pkg::PH_FIRST;
			end
		end else if (busy) begin
			if (tick_inc >= hp) begin
				tick_n = 12'd0;
				priority if (phase_q == slms_pkg::PH_TAIL) begin
					reply.done  = 1'b1;
					reply.reply = rx_shift_q;
					reply.last  = last_q;
					phase_n     = slms_pkg::PH_IDLE;
				end else if (phase_q[0]) begin
					rx_shift_n = {rx_shift_q[6:0], serial_in};
					clock_n    = 1'b1;
					phase_n    = phase_q + 5'd1;
				end else if (phase_q == slms_pkg::PH_LAST_HIGH) begin
					data_n  = 1'b0;
					phase_n = slms_pkg::PH_TAIL;
				end else begin
					tx_shift_n = {tx_shift_q[6:0], 1'b0};
					data_n     = tx_shift_q[6];
					clock_n    = 1'b0;
					phase_n    = phase_q + 5'd1;
				end
			end else begin
				tick_n = tick_inc;
			end
		end
		line.clock_level = clock_n;
		line.data_level  = data_n;
		line.busy = (phase_n >= slms_pkg::PH_FIRST) && (phase_n <= slms_pkg::PH_TAIL);
	end

	// engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q <= '0;
			rx_shift_q <= '0;
			phase_q    <= slms_pkg::PH_IDLE;
			tick_q     <= '0;
			last_q     <= 1'b0;
			clock_q    <= 1'b0;
			data_q     <= 1'b0;
		end else if (step) begin
			tx_shift_q <= tx_shift_n;
			rx_shift_q <= rx_shift_n;
			phase_q    <= phase_n;
			tick_q     <= tick_n;
			last_q     <= last_n;
			clock_q    <= clock_n;
			data_q     <= data_n;
		end
	end

endmodule

// ===== rtl/core/slms_track.sv =====
// sync and status tracker fed by finished reply bytes
module slms_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  slms_pkg::slms_reply_t reply,
	output logic [7:0]            link_status
);

	logic       sync_q, sync_n;
	logic [7:0] after_sync_q, after_sync_n;
	logic [7:0] nonidle_q, nonidle_n;
	logic       any_q, any_n;
	logic [7:0] status_q;

	// tracker update for one reply, then packet close
	always_comb begin
		sync_n       = sync_q;
		after_sync_n = after_sync_q;
		nonidle_n    = nonidle_q;
		any_n        = any_q;
		link_status  = status_q;
		if (reply.done) begin
			priority if (sync_q) begin
				after_sync_n = reply.reply;
				sync_n       = 1'b0;
				any_n        = 1'b1;
			end else if (reply.reply == slms_pkg::SYNC_BYTE) begin
				sync_n = 1'b1;
				any_n  = 1'b1;
			end else if (reply.reply != slms_pkg::IDLE_LOW &&
					reply.reply != slms_pkg::DISCONNECTED) begin
				nonidle_n = reply.reply;
				any_n     = 1'b1;
			end else begin
				// idle codes leave the tracker as it is
				any_n = any_q;
			end
			if (reply.last) begin
				priority if (!any_n) begin
					link_status = slms_pkg::DISCONNECTED;
				end else if (after_sync_n != 8'd0) begin
					link_status = after_sync_n;
				end else begin
					link_status = nonidle_n;
				end
				sync_n       = 1'b0;
				after_sync_n = 8'd0;
				nonidle_n    = 8'd0;
				any_n        = 1'b0;
			end
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q       <= 1'b0;
			after_sync_q <= '0;
			nonidle_q    <= '0;
			any_q        <= 1'b0;
			status_q     <= slms_pkg::DISCONNECTED;
		end else if (step) begin
			sync_q       <= sync_n;
			after_sync_q <= after_sync_n;
			nonidle_q    <= nonidle_n;
			any_q        <= any_n;
			status_q     <= link_status;
		end
	end

endmodule

// ===== rtl/core/serial_link_master_status.sv =====
// top level: input register, bit engine, status tracker, result register, apb port
//
// channel   dir  group                          word
// s_axis    in   s_tvalid/s_tready/s_tdata      tick or byte load, op on tuser, eop on tlast
// m_axis    out  m_tvalid/m_tready/m_tdata      line levels, flags, reply, status; tlast = packet done
// apb       in   psel/penable/pwrite/paddr      half period register at address 0
//
// one word per cycle sustained while m_tready holds; a taken word goes into the input register,
// then the engine and tracker settle it into the result register
// reset clears all but the input and result data; link status starts at 0xff, half period at 62
// a stall on the result side holds the result register and then the input register

module serial_link_master_status (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: tx_byte [7:0], serial_in [8], zero [15:9]
	input  logic [15:0] s_tdata,
	// s_tuser: op
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: clock_out [0], data_out [1], busy_res [2], refused [3], byte_done [4],
	//          reply_byte [12:5], link_status [20:13], zero [23:21]
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  txb_s1;
	logic        eop_s1;
	logic        sin_s1;
	logic        adv;
	logic [11:0] half_period_q;
	logic        out_valid_q;
	logic [23:0] out_data_q;
	logic        out_last_q;
	logic [7:0]  status;
	slms_pkg::slms_reply_t reply;
	slms_pkg::slms_line_t  line;

	// apb register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == slms_pkg::REG_HALF_PERIOD) ? {20'd0, half_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= slms_pkg::HALF_PERIOD_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == slms_pkg::REG_HALF_PERIOD) begin
			half_period_q <= pwdata[11:0];
		end
	end

	// handshake: the held word moves on when the result register is empty or m_tready drains it
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			txb_s1 <= s_tdata[7:0];
			sin_s1 <= s_tdata[8];
			eop_s1 <= s_tlast;
		end
	end

	slms_link u_link (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.op            (op_s1),
		.tx_byte       (txb_s1),
		.end_of_packet (eop_s1),
		.serial_in     (sin_s1),
		.half_period   (half_period_q),
		.reply         (reply),
		.line          (line)
	);

	slms_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.reply       (reply),
		.link_status (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {3'd0, status, reply.reply, reply.done, line.refused,
				line.busy, line.data_level, line.clock_level};
			out_last_q <= reply.done & reply.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
